[rtl/lbs_pkg.sv]
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants of the linear blend skinning unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbs_pkg;

  // Table geometry
  localparam int JOINTS      = 24;
  localparam int ELEMS       = 16;
  localparam int TABLE_DEPTH = JOINTS * ELEMS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // Fixed-point formats
  localparam int VERT_FRAC   = 20;
  localparam int WEIGHT_FRAC = 16;
  localparam int ELEM_W      = 32;
  localparam int VERT_W      = 24;
  localparam int WEIGHT_W    = 17;
  localparam int PROD_W      = ELEM_W + VERT_W;        // Q12.44 product
  localparam int D_W         = PROD_W + 2;             // sum of four products
  localparam int S_W         = D_W - VERT_FRAC;        // Q14.24 row value
  localparam int T_W         = S_W + WEIGHT_W + 1;     // weighted row value
  localparam int U_W         = T_W - WEIGHT_FRAC;      // rounded weighted value
  localparam int ACC_W       = 56;
  localparam int OUT_W       = 32;

  // Homogeneous coordinate 1.0 in Q4.20
  localparam logic signed [VERT_W-1:0] V_ONE = VERT_W'(1 << VERT_FRAC);

  // Action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TERM = 1'b1;

  typedef struct packed {
    logic                        action;
    logic [4:0]                  joint;
    logic [3:0]                  element;
    logic signed [ELEM_W-1:0]    element_value;
    logic [WEIGHT_W-1:0]         weight;
    logic signed [VERT_W-1:0]    vertex_x;
    logic signed [VERT_W-1:0]    vertex_y;
    logic signed [VERT_W-1:0]    vertex_z;
    logic                        last_term;
  } lbs_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
    logic signed [OUT_W-1:0] out_w;
    logic                    saturated;
  } lbs_out_t;

  // Controller to datapath
  typedef struct packed {
    logic       tbl_we;   // write table element from input transfer
    logic       latch;    // capture term fields from input transfer
    logic       rd;       // read table element at (row, col)
    logic       mul;      // element times vertex component
    logic       add;      // accumulate row dot product
    logic       d_first;  // first column of a row
    logic       rnd;      // round dot product to Q14.24
    logic       wmul;     // multiply by weight
    logic       acc;      // round and add into row accumulator
    logic       emit;     // load output register, clear accumulators
    logic [1:0] row;
    logic [1:0] col;
  } lbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_term;
    logic in_joint_ok;
    logic last_term;
    logic out_free;
  } lbs_stat_t;

endpackage

`default_nettype wire

[rtl/lbs_ctrl.sv]
// ----------------------------------------------------------------------------
// lbs_ctrl
// Sequencer: walks the sixteen table elements of a term, row by row, and
// steps the datapath through multiply, round, weight and accumulate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire lbs_pkg::lbs_stat_t stat_i,
  output lbs_pkg::lbs_cmd_t      cmd_o
);
  import lbs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ADD,
    ST_RND,
    ST_WMUL,
    ST_ACC,
    ST_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] row_q, row_d;
  logic [1:0] col_q, col_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    cmd_o   = '0;
    cmd_o.row = row_q;
    cmd_o.col = col_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (stat_i.in_term == ACT_TERM) begin
            cmd_o.latch = 1'b1;
            row_d       = '0;
            col_d       = '0;
            state_d     = stat_i.in_joint_ok ? ST_READ : ST_FIN;
          end else begin
            cmd_o.tbl_we = stat_i.in_joint_ok;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add     = 1'b1;
        cmd_o.d_first = (col_q == 2'd0);
        col_d         = col_q + 2'd1;
        state_d       = (col_q == 2'd3) ? ST_RND : ST_READ;
      end
      ST_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = ST_WMUL;
      end
      ST_WMUL: begin
        cmd_o.wmul = 1'b1;
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        row_d     = row_q + 2'd1;
        state_d   = (row_q == 2'd3) ? ST_FIN : ST_READ;
      end
      ST_FIN: begin
        // a vertex result waits here until the output register is free
        if (!stat_i.last_term) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

endmodule

`default_nettype wire

[rtl/lbs_datapath.sv]
// ----------------------------------------------------------------------------
// lbs_datapath
// Transform table, multiply and round chain, row accumulators and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbs_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lbs_pkg::lbs_in_t  in_data_i,
  input  wire lbs_pkg::lbs_cmd_t cmd_i,
  output lbs_pkg::lbs_stat_t     stat_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lbs_pkg::lbs_out_t      out_data_o
);
  import lbs_pkg::*;

  // Clip a 56-bit accumulator to Q8.24, flag when clipped
  function automatic logic [OUT_W:0] clip_out(input logic signed [ACC_W-1:0] a);
    logic all_same;
    all_same = (a[ACC_W-1:OUT_W-1] == '0) || (a[ACC_W-1:OUT_W-1] == '1);
    if (all_same) begin
      clip_out = {1'b0, a[OUT_W-1:0]};
    end else if (a[ACC_W-1]) begin
      clip_out = {1'b1, 1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      clip_out = {1'b1, 1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  logic [ELEM_W-1:0]        mem [TABLE_DEPTH];
  logic signed [ELEM_W-1:0] rd_data_q;

  logic [4:0]               joint_q;
  logic [WEIGHT_W-1:0]      w_q;
  logic signed [VERT_W-1:0] vx_q, vy_q, vz_q;
  logic                     last_q;

  logic signed [VERT_W-1:0] v_sel;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [D_W-1:0]    d_d, d_q, d_rnd;
  logic signed [S_W-1:0]    s_q;
  logic signed [T_W-1:0]    t_d, t_q, t_rnd;
  logic signed [U_W-1:0]    u;
  logic signed [ACC_W:0]    a_sum;
  logic signed [ACC_W-1:0]  a_sat;
  logic signed [ACC_W-1:0]  acc_q [4];

  logic [OUT_W:0]           cx, cy, cz, cw;
  logic                     out_valid_q;
  lbs_out_t                 out_q;

  logic [ADDR_W-1:0]        wr_addr, rd_addr;

  // Status towards the controller
  assign stat_o.in_term     = in_data_i.action;
  assign stat_o.in_joint_ok = int'(in_data_i.joint) < JOINTS;
  assign stat_o.last_term   = last_q;
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  assign wr_addr = ADDR_W'({in_data_i.joint, in_data_i.element});
  assign rd_addr = ADDR_W'({joint_q, cmd_i.col, cmd_i.row});

  // Vertex component for the current column
  always_comb begin
    case (cmd_i.col)
      2'd0:    v_sel = vx_q;
      2'd1:    v_sel = vy_q;
      2'd2:    v_sel = vz_q;
      default: v_sel = V_ONE;
    endcase
  end

  // Arithmetic chain
  assign prod_d = rd_data_q * v_sel;
  assign d_d    = (cmd_i.d_first ? D_W'(0) : d_q) + D_W'(prod_q);
  assign d_rnd  = d_q + (D_W'(1) <<< (VERT_FRAC - 1));
  assign t_d    = s_q * $signed({1'b0, w_q});
  assign t_rnd  = t_q + (T_W'(1) <<< (WEIGHT_FRAC - 1));
  assign u      = t_rnd[T_W-1:WEIGHT_FRAC];
  assign a_sum  = (ACC_W+1)'(acc_q[cmd_i.row]) + (ACC_W+1)'(u);

  // Saturate the accumulator sum to 56 bits
  always_comb begin
    if (a_sum[ACC_W] != a_sum[ACC_W-1]) begin
      a_sat = a_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      a_sat = a_sum[ACC_W-1:0];
    end
  end

  assign cx = clip_out(acc_q[0]);
  assign cy = clip_out(acc_q[1]);
  assign cz = clip_out(acc_q[2]);
  assign cw = clip_out(acc_q[3]);

  // Transform table
  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_we) begin
      mem[wr_addr] <= in_data_i.element_value;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Term capture, pipeline and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      joint_q <= in_data_i.joint;
      w_q     <= in_data_i.weight;
      vx_q    <= in_data_i.vertex_x;
      vy_q    <= in_data_i.vertex_y;
      vz_q    <= in_data_i.vertex_z;
    end
    if (cmd_i.mul)  prod_q <= prod_d;
    if (cmd_i.add)  d_q    <= d_d;
    if (cmd_i.rnd)  s_q    <= d_rnd[D_W-1:VERT_FRAC];
    if (cmd_i.wmul) t_q    <= t_d;
    if (cmd_i.emit) begin
      out_q.out_x     <= cx[OUT_W-1:0];
      out_q.out_y     <= cy[OUT_W-1:0];
      out_q.out_z     <= cz[OUT_W-1:0];
      out_q.out_w     <= cw[OUT_W-1:0];
      out_q.saturated <= cx[OUT_W] | cy[OUT_W] | cz[OUT_W] | cw[OUT_W];
    end
  end

  // Accumulators, last-term flag and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) acc_q[i] <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        last_q <= in_data_i.last_term;
      end
      if (cmd_i.emit) begin
        for (int i = 0; i < 4; i++) acc_q[i] <= '0;
      end else if (cmd_i.acc) begin
        acc_q[cmd_i.row] <= a_sat;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // a result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("emit while output register held");

  // accumulators start empty for the next vertex
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (acc_q[0] == '0 && acc_q[1] == '0 && acc_q[2] == '0 &&
                    acc_q[3] == '0 && out_valid_q))
    else $error("accumulators not cleared after emit");

  // accumulate always follows the weight multiply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc |-> $past(cmd_i.wmul))
    else $error("accumulate without weight multiply");
`endif

endmodule

`default_nettype wire

[rtl/linear_blend_skinning_unit.sv]
// ----------------------------------------------------------------------------
// linear_blend_skinning_unit
// Skins vertices against a table of per-joint 4x4 transforms.
// ----------------------------------------------------------------------------
// A load transfer (action 0) writes one Q8.24 element of one joint's
// transform; loads to joints beyond the table are dropped. A term transfer
// (action 1) adds weight * (T_joint * v) into four row accumulators; the
// term flagged last_term then delivers x, y, z and w, clipped to Q8.24 with
// a saturated flag, and clears the accumulators. For a term whose joint is
// in range, the single-port transform table is read one element at a time,
// each element costs a read, a multiply and an add, and each of the four
// rows then rounds, weights and accumulates. A term for a joint out of range
// adds nothing. Input stall is high whenever a term is in progress; a
// finished result sits in the output register, so new items are taken while
// it waits. The table is undefined after reset until written.
`timescale 1ns / 1ps
`default_nettype none

module linear_blend_skinning_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire lbs_pkg::lbs_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output lbs_pkg::lbs_out_t     out_data_o
);
  import lbs_pkg::*;

  lbs_cmd_t  cmd;
  lbs_stat_t stat;

  // Sequencer
  lbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table and arithmetic
  lbs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[tb/linear_blend_skinning_unit_tb.sv]
// ----------------------------------------------------------------------------
// linear_blend_skinning_unit_tb
// Self-checking testbench for the linear blend skinning unit.
// ----------------------------------------------------------------------------
// A queue of pending transfers feeds a clocked driver. Transform loads and
// skinning terms are predicted in order as each input transfer is taken, and
// every predicted vertex joins a queue. A clocked monitor pops that queue and
// checks each result field by field. A short directed run covers the extremes,
// out-of-range joints, ignored fields and rounding. Random vertices of one to
// four terms then follow, mixed with joint reloads and stray transfers. Both
// sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_blend_skinning_unit_tb;

  import lbs_pkg::*;

  localparam int          DIRECTED_ITEMS = 25;
  localparam int          RANDOM_ITEMS   = 1200;
  localparam int          SETTLE_CYCLES  = 200;
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;

  localparam logic [ELEM_W-1:0] ONE_Q24 = ELEM_W'(1 << 24);

  localparam longint ACC_HI = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint OUT_HI = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_LO = -OUT_HI - 1;

  typedef struct {
    lbs_in_t item;
    bit      drain;   // hold off until every pending vertex has come back
  } feed_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  lbs_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lbs_out_t out_data;

  // Predictor state
  logic signed [ELEM_W-1:0] xform_tbl [TABLE_DEPTH];
  longint                   blend_acc [4];

  // Stimulus bookkeeping
  feed_t       pending_q [$];
  lbs_out_t    skinned_q [$];
  logic [15:0] loaded_mask [JOINTS];
  bit          pause_next = 1'b0;
  int          gen_cnt    = 0;

  int          err_cnt    = 0;
  int          vertex_cnt = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned drv_gap    = 0;
  int unsigned mon_hold   = 0;
  bit          drv_calm   = 1'b0;
  bit          mon_calm   = 1'b0;

  linear_blend_skinning_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic helpers
  // ---------------------------------------------------------------------------

  // Round half up, then arithmetic shift right by k
  function automatic longint round_shr(input longint x, input int k);
    return (x + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clamp(input longint x, input longint lo, input longint hi,
                                   output bit hit);
    hit = 1'b1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    hit = 1'b0;
    return x;
  endfunction

  // Apply one input transfer to the predicted state; queue a vertex if emitted
  task automatic skin_step(input lbs_in_t t);
    longint   vec [4];
    longint   comp [4];
    longint   dot;
    longint   row_q;
    longint   wtd;
    bit       hit;
    bit       any_hit;
    lbs_out_t res;
    int       base;
    base = int'(t.joint) * ELEMS;
    if (t.action == ACT_LOAD) begin
      if (t.joint < JOINTS) xform_tbl[base + int'(t.element)] = t.element_value;
      return;
    end
    if (t.joint < JOINTS) begin
      vec[0] = longint'($signed(t.vertex_x));
      vec[1] = longint'($signed(t.vertex_y));
      vec[2] = longint'($signed(t.vertex_z));
      vec[3] = longint'(1) << VERT_FRAC;
      for (int r = 0; r < 4; r++) begin
        dot = 0;
        for (int c = 0; c < 4; c++)
          dot += longint'(xform_tbl[base + c * 4 + r]) * vec[c];
        row_q = round_shr(dot, VERT_FRAC);
        wtd   = round_shr(row_q * longint'({1'b0, t.weight}), WEIGHT_FRAC);
        blend_acc[r] = clamp(blend_acc[r] + wtd, ACC_LO, ACC_HI, hit);
      end
    end
    if (t.last_term) begin
      any_hit = 1'b0;
      for (int r = 0; r < 4; r++) begin
        comp[r]      = clamp(blend_acc[r], OUT_LO, OUT_HI, hit);
        any_hit      = any_hit | hit;
        blend_acc[r] = 0;
      end
      res.out_x     = OUT_W'(comp[0]);
      res.out_y     = OUT_W'(comp[1]);
      res.out_z     = OUT_W'(comp[2]);
      res.out_w     = OUT_W'(comp[3]);
      res.saturated = any_hit;
      skinned_q = {skinned_q, res};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] got,
                             input logic [OUT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("vertex %0d %s: got %h, expected %h",
                                vertex_cnt, name, got, want));
  endtask

  task automatic check_vertex(input lbs_out_t got);
    lbs_out_t want;
    if (skinned_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
    end else begin
      want = skinned_q.pop_front();
      check_field("out_x", got.out_x, want.out_x);
      check_field("out_y", got.out_y, want.out_y);
      check_field("out_z", got.out_z, want.out_z);
      check_field("out_w", got.out_w, want.out_w);
      check_field("saturated", OUT_W'(got.saturated), OUT_W'(want.saturated));
    end
    vertex_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  // Idle or stall length for one transfer; calm stretches have none
  function automatic int unsigned draw_wait(input bit calm);
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : $urandom_range(0, 2);
  endfunction

  // Every field random; builders then overwrite the fields that matter
  function automatic lbs_in_t scramble();
    lbs_in_t t;
    t.action        = 1'($urandom());
    t.joint         = 5'($urandom());
    t.element       = 4'($urandom());
    t.element_value = $urandom();
    t.weight        = WEIGHT_W'($urandom());
    t.vertex_x      = VERT_W'($urandom());
    t.vertex_y      = VERT_W'($urandom());
    t.vertex_z      = VERT_W'($urandom());
    t.last_term     = 1'($urandom());
    return t;
  endfunction

  task automatic push_feed(input lbs_in_t t);
    feed_t f;
    f.item     = t;
    f.drain    = pause_next;
    pause_next = 1'b0;
    pending_q  = {pending_q, f};
    gen_cnt++;
  endtask

  task automatic push_load(input int j, input int e, input logic [ELEM_W-1:0] v);
    lbs_in_t t;
    t               = scramble();
    t.action        = ACT_LOAD;
    t.joint         = 5'(j);
    t.element       = 4'(e);
    t.element_value = v;
    if (j < JOINTS) loaded_mask[j][e] = 1'b1;
    push_feed(t);
  endtask

  task automatic push_term(input int j, input logic [WEIGHT_W-1:0] w,
                           input logic [VERT_W-1:0] x, input logic [VERT_W-1:0] y,
                           input logic [VERT_W-1:0] z, input bit last);
    lbs_in_t t;
    t           = scramble();
    t.action    = ACT_TERM;
    t.joint     = 5'(j);
    t.weight    = w;
    t.vertex_x  = x;
    t.vertex_y  = y;
    t.vertex_z  = z;
    t.last_term = last;
    push_feed(t);
  endtask

  // Element value: near-rigid, fully random, or an extreme
  function automatic logic [ELEM_W-1:0] pick_element(input int kind, input int e);
    if (kind == 1) return $urandom();
    if (kind == 2) begin
      case ($urandom_range(0, 4))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return '0;
        3:       return ONE_Q24;
        default: return '1;
      endcase
    end
    if (e % 4 == 3) return (e == 15) ? ONE_Q24 : '0;   // bottom row
    if (e % 5 == 0) return ONE_Q24 + ELEM_W'($urandom_range(0, 1 << 23)) - ELEM_W'(1 << 22);
    return ELEM_W'($urandom_range(0, 1 << 25)) - ELEM_W'(1 << 24);
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WEIGHT_W'(65536);
      2:       return '1;
      3, 4:    return WEIGHT_W'($urandom_range(65536, 131071));
      default: return WEIGHT_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [VERT_W-1:0] pick_coord(input int style);
    case (style)
      0:       return VERT_W'($urandom());
      1:       return $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
      default: return VERT_W'($urandom_range(0, 1 << 21)) - VERT_W'(1 << 20);
    endcase
  endfunction

  // Load a whole joint transform, starting at a random element
  task automatic load_joint(input int j);
    int kind;
    int start;
    kind  = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);
    start = $urandom_range(0, ELEMS - 1);
    for (int i = 0; i < ELEMS; i++)
      push_load(j, (start + i) % ELEMS, pick_element(kind, (start + i) % ELEMS));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents pending transfers, predicting each one as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : driver
    logic        nxt_valid;
    lbs_in_t     nxt_data;
    int unsigned nxt_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      drv_gap  <= 0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      nxt_gap   = drv_gap;
      if (in_valid && !in_stall) begin
        skin_step(in_data);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (nxt_gap != 0) begin
          nxt_gap = nxt_gap - 1;
        end else if (pending_q.size() != 0 &&
                     (!pending_q[0].drain || skinned_q.size() == 0)) begin
          nxt_data  = pending_q[0].item;
          nxt_valid = 1'b1;
          void'(pending_q.pop_front());
          if ($urandom_range(0, 63) == 0) drv_calm = !drv_calm;
          nxt_gap = draw_wait(drv_calm);
        end
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
      drv_gap  <= nxt_gap;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stalls the result channel at random and checks each transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : monitor
    int unsigned nxt_hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      mon_hold  <= 0;
    end else begin
      nxt_hold = mon_hold;
      if (out_valid && !out_stall) begin
        check_vertex(out_data);
        if ($urandom_range(0, 63) == 0) mon_calm = !mon_calm;
        nxt_hold = draw_wait(mon_calm);
      end else if (out_valid && mon_hold != 0) begin
        nxt_hold = mon_hold - 1;
      end
      mon_hold  <= nxt_hold;
      out_stall <= (nxt_hold != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int          ready [$];
    int          nterms;
    int          pick;
    int          style;
    int          j;
    logic [23:0] vx;
    logic [23:0] vy;
    logic [23:0] vz;

    for (int i = 0; i < TABLE_DEPTH; i++) xform_tbl[i] = '0;
    for (int r = 0; r < 4; r++) blend_acc[r] = 0;
    for (int i = 0; i < JOINTS; i++) loaded_mask[i] = '0;

    // Directed: joint 0 as identity with extreme translation
    for (int e = 0; e < ELEMS; e++) begin
      case (e)
        0, 5, 10, 15: push_load(0, e, ONE_Q24);
        12:           push_load(0, e, 32'h7FFF_FFFF);
        13:           push_load(0, e, 32'h8000_0000);
        14:           push_load(0, e, 32'h0010_0000);
        default:      push_load(0, e, '0);
      endcase
    end
    // loads beyond the table are dropped
    push_load(31, 15, $urandom());
    push_load(JOINTS, 0, $urandom());
    // zero weight gives a zero vertex
    push_term(0, '0, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 1'b1);
    // full and above-unity weights on extreme coordinates clip
    push_term(0, WEIGHT_W'(65536), 24'h7F_FFFF, 24'h80_0000, 24'h00_0000, 1'b0);
    push_term(0, '1, 24'h80_0000, 24'h7F_FFFF, 24'hFF_FFFF, 1'b1);
    // a lone out-of-range term still delivers an (empty) vertex
    push_term(JOINTS, WEIGHT_W'(65536), 24'h12_3456, 24'h65_4321, 24'h00_0001, 1'b1);
    // out-of-range term mid-vertex, then rounding of the smallest values
    push_term(31, '1, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 1'b0);
    push_term(0, WEIGHT_W'(1), 24'h00_0001, 24'h00_0001, 24'h00_0001, 1'b1);
    push_term(0, WEIGHT_W'(32768), '0, '0, '0, 1'b1);

    // Random: wait for the directed vertices first, start with a few joints
    pause_next = 1'b1;
    for (int i = 1; i < 5; i++) load_joint(i);
    while (gen_cnt < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      ready.delete();
      for (int i = 0; i < JOINTS; i++)
        if (loaded_mask[i] == 16'hFFFF) ready = {ready, i};
      if (pick < 10) begin
        load_joint($urandom_range(0, JOINTS - 1));
      end else if (pick < 18) begin
        // stray single-element load, possibly out of range
        push_load($urandom_range(0, 31), $urandom_range(0, ELEMS - 1), $urandom());
      end else if (pick < 22) begin
        push_term($urandom_range(JOINTS, 31), pick_weight(), VERT_W'($urandom()),
                  VERT_W'($urandom()), VERT_W'($urandom()), 1'($urandom()));
      end else begin
        // a well-formed vertex of one to four terms
        if ($urandom_range(0, 49) == 0) pause_next = 1'b1;
        nterms = $urandom_range(1, 4);
        style  = ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 2);
        vx     = pick_coord(style);
        vy     = pick_coord(style);
        vz     = pick_coord(style);
        for (int n = 0; n < nterms; n++) begin
          if ($urandom_range(0, 19) == 0) j = $urandom_range(JOINTS, 31);
          else j = ready[$urandom_range(0, ready.size() - 1)];
          push_term(j, pick_weight(), vx, vy, vz, n == nterms - 1);
        end
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (skinned_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lbs_pkg.sv
rtl/lbs_ctrl.sv
rtl/lbs_datapath.sv
rtl/linear_blend_skinning_unit.sv
tb/linear_blend_skinning_unit_tb.sv
